FILE: design/tcbad_pkg.sv
// Package for the two-channel block average decimator.
// Holds field widths, register indexes, reset values and the divider status type.
// No dependencies.
package tcbad_pkg;

   localparam int SAMPLE_W = 32;
   localparam int DEC_W    = 15;
   localparam int BLK_W    = 16;
   localparam int IDX_W    = 1;
   localparam int STEP_W   = $clog2(SAMPLE_W);

   localparam logic [IDX_W-1:0]  REG_DECIMATION   = 1'b0;
   localparam logic [IDX_W-1:0]  REG_RAW_MODE     = 1'b1;
   localparam logic [DEC_W-1:0]  DECIMATION_RESET = 15'd800;
   localparam logic [STEP_W-1:0] LAST_STEP        = STEP_W'(SAMPLE_W - 1);

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

FILE: design/tcbad_div.sv
// Radix-2 restoring divider shared by both channels, one quotient bit per cycle.
// Divides a 32-bit unsigned dividend by a nonzero 15-bit divisor.
// Depends on tcbad_pkg.
module tcbad_div
   import tcbad_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SAMPLE_W-1:0] dividend,
   input  logic [DEC_W-1:0]    divisor,
   output logic [SAMPLE_W-1:0] quotient,
   output div_status_type      status
);

   logic [SAMPLE_W-1:0] dvd_ff, dvd_in;
   logic [DEC_W-1:0]    rem_ff, rem_in;
   logic [DEC_W-1:0]    dvs_ff, dvs_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DEC_W:0]      trial;
   logic [DEC_W+1:0]    diff;

   always_comb begin
      trial   = {rem_ff, dvd_ff[SAMPLE_W-1]};
      diff    = {1'b0, trial} - {2'b00, dvs_ff};
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         if (!diff[DEC_W+1]) begin
            rem_in = diff[DEC_W-1:0];
         end else begin
            rem_in = trial[DEC_W-1:0];
         end
         dvd_in = {dvd_ff[SAMPLE_W-2:0], ~diff[DEC_W+1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient    = dvd_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

FILE: design/two_channel_block_average_decimator.sv
// Two-channel block average decimator.
// Sums two sample channels over blocks and emits averages or the last raw pair.
// Depends on tcbad_pkg and tcbad_div.
//
// Each req item carries one sample pair. Both channels are summed modulo 2^32
// over a block of decimation samples; zero decimation acts as one. The item
// that completes a block produces one rsp item holding the block number and
// either both sums divided by decimation or that item's raw sample pair.
// An item that does not end a block leaves req_tready high for the next item.
// An item that ends a block in average mode keeps the block busy while one
// restoring divider, producing one quotient bit per cycle, serves the two
// channels in turn; in raw mode such an item goes straight to the output state.
// req_tready is low while a block result is being formed.
// The result sits in an output register, so further items are taken while it
// waits. If the receiver stalls and another block ends, the block waits until
// the register frees. Configuration is to be written through the csr port only
// while the block is idle; the block itself does not enforce this. Reset restores
// decimation 800, average mode, cleared sums, sample count and block number.
module two_channel_block_average_decimator
   import tcbad_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [2*SAMPLE_W-1:0]   req_tdata,  // sample_a, sample_b
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [BLK_W+2*SAMPLE_W-1:0] rsp_tdata, // block_number, value_a, value_b
   input  logic                    csr_we,
   input  logic [IDX_W-1:0]        csr_index,
   input  logic [DEC_W-1:0]        csr_wdata
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_DIV_A = 2'd1;
   localparam logic [1:0] ST_DIV_B = 2'd2;
   localparam logic [1:0] ST_OUT   = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [DEC_W-1:0]    dec_ff, dec_in;
   logic                raw_ff, raw_in;
   logic [SAMPLE_W-1:0] sum_a_ff, sum_a_in;
   logic [SAMPLE_W-1:0] sum_b_ff, sum_b_in;
   logic [DEC_W-1:0]    cnt_ff, cnt_in;
   logic [BLK_W-1:0]    blk_ff, blk_in;
   logic [SAMPLE_W-1:0] last_a_ff, last_a_in;
   logic [SAMPLE_W-1:0] last_b_ff, last_b_in;
   logic [SAMPLE_W-1:0] quot_a_ff, quot_a_in;
   logic [SAMPLE_W-1:0] quot_b_ff, quot_b_in;
   logic                start_ff, start_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BLK_W+2*SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;

   logic [DEC_W-1:0]    divisor;
   logic [DEC_W:0]      count;
   logic                block_end;
   logic                accept;
   logic [SAMPLE_W-1:0] div_quotient;
   div_status_type      div_status;

   assign divisor    = (dec_ff == '0) ? DEC_W'(1) : dec_ff;
   assign count      = {1'b0, cnt_ff} + 1'b1;
   assign block_end  = (count >= {1'b0, divisor});
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   tcbad_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend ((state_ff == ST_DIV_B) ? sum_b_ff : sum_a_ff),
      .divisor  (divisor),
      .quotient (div_quotient),
      .status   (div_status)
   );

   always_comb begin
      state_in     = state_ff;
      dec_in       = dec_ff;
      raw_in       = raw_ff;
      sum_a_in     = sum_a_ff;
      sum_b_in     = sum_b_ff;
      cnt_in       = cnt_ff;
      blk_in       = blk_ff;
      last_a_in    = last_a_ff;
      last_b_in    = last_b_ff;
      quot_a_in    = quot_a_ff;
      quot_b_in    = quot_b_ff;
      start_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (csr_we) begin
         unique case (csr_index)
            REG_DECIMATION: dec_in = csr_wdata;
            REG_RAW_MODE:   raw_in = csr_wdata[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sum_a_in  = sum_a_ff + req_tdata[SAMPLE_W-1:0];
               sum_b_in  = sum_b_ff + req_tdata[2*SAMPLE_W-1:SAMPLE_W];
               last_a_in = req_tdata[SAMPLE_W-1:0];
               last_b_in = req_tdata[2*SAMPLE_W-1:SAMPLE_W];
               if (block_end) begin
                  cnt_in = '0;
                  if (raw_ff) begin
                     state_in = ST_OUT;
                  end else begin
                     state_in = ST_DIV_A;
                     start_in = 1'b1;
                  end
               end else begin
                  cnt_in = count[DEC_W-1:0];
               end
            end
         end
         ST_DIV_A: begin
            if (div_status.done) begin
               quot_a_in = div_quotient;
               start_in  = 1'b1;
               state_in  = ST_DIV_B;
            end
         end
         ST_DIV_B: begin
            if (div_status.done) begin
               quot_b_in = div_quotient;
               state_in  = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (raw_ff) begin
                  rsp_data_in = {last_b_ff, last_a_ff, blk_ff};
               end else begin
                  rsp_data_in = {quot_b_ff, quot_a_ff, blk_ff};
               end
               sum_a_in = '0;
               sum_b_in = '0;
               blk_in   = blk_ff + 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      last_a_ff   <= last_a_in;
      last_b_ff   <= last_b_in;
      quot_a_ff   <= quot_a_in;
      quot_b_ff   <= quot_b_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         dec_ff       <= DECIMATION_RESET;
         raw_ff       <= 1'b0;
         sum_a_ff     <= '0;
         sum_b_ff     <= '0;
         cnt_ff       <= '0;
         blk_ff       <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dec_ff       <= dec_in;
         raw_ff       <= raw_in;
         sum_a_ff     <= sum_a_in;
         sum_b_ff     <= sum_b_in;
         cnt_ff       <= cnt_in;
         blk_ff       <= blk_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_status.busy)
      else $error("Divider busy while items are accepted.");

   assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIV_A || state_ff == ST_DIV_B))
      else $error("Quotient finished outside a divide state.");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("Result raised without passing through the output state.");

   assert property (@(posedge clock) disable iff (reset)
      start_ff |-> !div_status.busy)
      else $error("Divider started while still busy.");

endmodule
